// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers. Simulation gets the checks; synthesis
// gets empty bodies.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every rising edge outside reset.
`define LFU_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("%m: assertion failed");

// Expression must never be true outside reset.
`define LFU_ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("%m: forbidden condition seen");

`else

`define LFU_ASSERT(lbl, clk, rst_n, prop)
`define LFU_ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

// ===== design/lfu_pkg.sv =====
// ----------------------------------------------------------------------------
// lfu_pkg
// Types and constants shared by the LFU cache, its channel interfaces and
// its sequencer.
// ----------------------------------------------------------------------------
package lfu_pkg;

	// Number of cache entries.
	localparam int ENTRIES = 16;
	// Width of an entry index and of a recency rank.
	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	// Width of an occupancy count, able to hold ENTRIES itself.
	localparam int CNT_W = $clog2(ENTRIES + 1);
	// Key, value and use count widths.
	localparam int DATA_W = 32;
	// Capacity register.
	localparam int CAP_W = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// Operation codes.
	localparam logic OP_GET = 1'b0;
	localparam logic OP_PUT = 1'b1;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_RANK,
		ST_DONE
	} lfu_state_t;

endpackage

// ===== design/lfu_req_if.sv =====
// ----------------------------------------------------------------------------
// lfu_req_if
// Request channel: one beat carries a get or a put with key and value.
// ----------------------------------------------------------------------------
interface lfu_req_if;
	import lfu_pkg::*;

	logic                     valid;
	logic                     ready;
	logic                     operation;
	logic signed [DATA_W-1:0] key;
	logic signed [DATA_W-1:0] value_in;

	modport source (output valid, output operation, output key, output value_in,
		input ready);
	modport sink (input valid, input operation, input key, input value_in,
		output ready);

endinterface

// ===== design/lfu_rsp_if.sv =====
// ----------------------------------------------------------------------------
// lfu_rsp_if
// Response channel: one beat per get, with hit flag and value.
// ----------------------------------------------------------------------------
interface lfu_rsp_if;
	import lfu_pkg::*;

	logic                     valid;
	logic                     ready;
	logic                     hit;
	logic signed [DATA_W-1:0] value_out;

	modport source (output valid, output hit, output value_out, input ready);
	modport sink (input valid, input hit, input value_out, output ready);

endinterface

// ===== design/lfu_cache_lru_tiebreak.sv =====
// ----------------------------------------------------------------------------
// lfu_cache_lru_tiebreak
// Key-value cache with least-frequently-used replacement; ties go to the
// least recently touched entry. One compare unit walks the entries under a
// small sequencer.
// ----------------------------------------------------------------------------
//
// Channel   Dir   Beat contents                  Beats
// req       in    operation, key, value_in       one per request
// rsp       out   hit, value_out                 one per get, none per put
// cfg       in    cfg_we, cfg_wdata (capacity)   single-cycle write
//
// A request runs the scan pass, the decide state, the rank pass when the recency
// ranks are updated (get hit, put hit, put with eviction), and the done state;
// the next accept waits for idle. The scan pass and the rank pass each visit
// one entry per cycle through the shared compare unit.
// Reset clears the valid bits and occupancy at once; no clearing pass.
// A stalled rsp holds the finished get in its final state until the output
// register frees; one result may wait while the next request is accepted.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lfu_cache_lru_tiebreak (
	input  logic                      clk,
	input  logic                      arst_n,
	lfu_req_if.sink                   req,
	lfu_rsp_if.source                 rsp,
	input  logic                      cfg_we,
	input  logic [lfu_pkg::CAP_W-1:0] cfg_wdata
);
	import lfu_pkg::*;

	// Entry storage.
	logic [ENTRIES-1:0] valid_q;
	logic [DATA_W-1:0]  keys_q   [ENTRIES];
	logic [DATA_W-1:0]  values_q [ENTRIES];
	logic [DATA_W-1:0]  counts_q [ENTRIES];
	logic [IDX_W-1:0]   ranks_q  [ENTRIES];
	logic [CNT_W-1:0]   occ_q;
	logic [CAP_W-1:0]   cap_q;

	// Sequencer and request registers.
	lfu_state_t        state_q, state_d;
	logic [IDX_W-1:0]  idx_q;
	logic              op_q;
	logic [DATA_W-1:0] key_q;
	logic [DATA_W-1:0] val_q;

	// Scan results.
	logic              found_q;
	logic [IDX_W-1:0]  hit_idx_q;
	logic [DATA_W-1:0] hit_val_q;
	logic [DATA_W-1:0] hit_cnt_q;
	logic [IDX_W-1:0]  hit_rank_q;
	logic              vic_found_q;
	logic [IDX_W-1:0]  vic_idx_q;
	logic [DATA_W-1:0] vic_cnt_q;
	logic [IDX_W-1:0]  vic_rank_q;
	logic              free_found_q;
	logic [IDX_W-1:0]  free_idx_q;

	// Rank pass target.
	logic [IDX_W-1:0]  target_q;
	logic [IDX_W-1:0]  old_rank_q;

	// Output register.
	logic              rsp_valid_q;
	logic              rsp_hit_q;
	logic [DATA_W-1:0] rsp_val_q;

	// Sequencer outputs.
	logic in_ready;
	logic scan_en;
	logic decide_en;
	logic rank_en;
	logic done_en;
	logic out_free;
	logic last_idx;

	// Decision signals.
	logic [CNT_W-1:0]  cap_eff;
	logic              put_new;
	logic              use_free;
	logic              use_vic;
	logic              need_rank;
	logic [IDX_W-1:0]  tgt;
	logic [DATA_W-1:0] cnt_inc;

	// Shared compare unit, looking at the entry under the index.
	logic cur_match;
	logic cur_better;

	assign last_idx = (idx_q == IDX_W'(ENTRIES - 1));
	assign out_free = !rsp_valid_q || rsp.ready;

	// Key match and victim order for the current entry.
	always_comb begin
		cur_match  = valid_q[idx_q] && (keys_q[idx_q] == key_q);
		cur_better = valid_q[idx_q] && (!vic_found_q ||
			(counts_q[idx_q] < vic_cnt_q) ||
			((counts_q[idx_q] == vic_cnt_q) && (ranks_q[idx_q] < vic_rank_q)));
	end

	// Effective capacity and the action for the request.
	always_comb begin
		if (32'(cap_q) > 32'(ENTRIES)) begin
			cap_eff = CNT_W'(ENTRIES);
		end else begin
			cap_eff = CNT_W'(cap_q);
		end
		put_new   = (op_q == OP_PUT) && !found_q;
		use_free  = put_new && (cap_eff != '0) && (occ_q < cap_eff) && free_found_q;
		use_vic   = put_new && (cap_eff != '0) && !use_free && vic_found_q;
		need_rank = found_q || use_vic;
		if (found_q) begin
			tgt = hit_idx_q;
		end else if (use_free) begin
			tgt = free_idx_q;
		end else begin
			tgt = vic_idx_q;
		end
		cnt_inc = (hit_cnt_q == '1) ? hit_cnt_q : hit_cnt_q + DATA_W'(1);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req.valid) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (last_idx) state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				state_d = need_rank ? ST_RANK : ST_DONE;
			end
			ST_RANK: begin
				if (last_idx) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (op_q == OP_PUT || out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		in_ready  = 1'b0;
		scan_en   = 1'b0;
		decide_en = 1'b0;
		rank_en   = 1'b0;
		done_en   = 1'b0;
		unique case (state_q)
			ST_IDLE:   in_ready = 1'b1;
			ST_SCAN:   scan_en = 1'b1;
			ST_DECIDE: decide_en = 1'b1;
			ST_RANK:   rank_en = 1'b1;
			ST_DONE:   done_en = (op_q == OP_GET) && out_free;
			default:   in_ready = 1'b0;
		endcase
	end

	assign req.ready     = in_ready;
	assign rsp.valid     = rsp_valid_q;
	assign rsp.hit       = rsp_hit_q;
	assign rsp.value_out = rsp_val_q;

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			idx_q        <= '0;
			valid_q      <= '0;
			occ_q        <= '0;
			cap_q        <= CAP_RESET;
			found_q      <= 1'b0;
			vic_found_q  <= 1'b0;
			free_found_q <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) cap_q <= cfg_wdata;

			// Index walks the entries in both passes.
			if (scan_en || rank_en) begin
				idx_q <= last_idx ? '0 : idx_q + IDX_W'(1);
			end

			// Clear the scan flags when a beat is taken.
			if (req.valid && in_ready) begin
				found_q      <= 1'b0;
				vic_found_q  <= 1'b0;
				free_found_q <= 1'b0;
				idx_q        <= '0;
			end

			// Scan pass: first match, best victim, first free slot.
			if (scan_en) begin
				if (cur_match && !found_q) found_q <= 1'b1;
				if (cur_better) vic_found_q <= 1'b1;
				if (!valid_q[idx_q] && !free_found_q) free_found_q <= 1'b1;
			end

			// Fill of a free slot.
			if (decide_en && use_free) begin
				valid_q[tgt] <= 1'b1;
				occ_q        <= occ_q + CNT_W'(1);
			end

			// Output register: a new result takes priority over draining.
			if (done_en) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (req.valid && in_ready) begin
			op_q  <= req.operation;
			key_q <= req.key;
			val_q <= req.value_in;
		end

		if (scan_en) begin
			if (cur_match && !found_q) begin
				hit_idx_q  <= idx_q;
				hit_val_q  <= values_q[idx_q];
				hit_cnt_q  <= counts_q[idx_q];
				hit_rank_q <= ranks_q[idx_q];
			end
			if (cur_better) begin
				vic_idx_q  <= idx_q;
				vic_cnt_q  <= counts_q[idx_q];
				vic_rank_q <= ranks_q[idx_q];
			end
			if (!valid_q[idx_q] && !free_found_q) free_idx_q <= idx_q;
		end

		// Entry writes for the chosen action.
		if (decide_en) begin
			target_q   <= tgt;
			old_rank_q <= found_q ? hit_rank_q : vic_rank_q;
			if (found_q) begin
				counts_q[tgt] <= cnt_inc;
				if (op_q == OP_PUT) values_q[tgt] <= val_q;
			end
			if (use_free || use_vic) begin
				keys_q[tgt]   <= key_q;
				values_q[tgt] <= val_q;
				counts_q[tgt] <= DATA_W'(1);
			end
			if (use_free) ranks_q[tgt] <= occ_q[IDX_W-1:0];
		end

		// Rank pass: newer entries move down, the target becomes most recent.
		if (rank_en) begin
			if (idx_q == target_q) begin
				ranks_q[idx_q] <= IDX_W'(occ_q - CNT_W'(1));
			end else if (valid_q[idx_q] && (ranks_q[idx_q] > old_rank_q)) begin
				ranks_q[idx_q] <= ranks_q[idx_q] - IDX_W'(1);
			end
		end

		// Result of a get.
		if (done_en) begin
			rsp_hit_q <= found_q;
			rsp_val_q <= found_q ? hit_val_q : '0;
		end
	end

	// Occupancy always matches the number of valid entries.
	`LFU_ASSERT(a_occ_matches_valid, clk, arst_n, $countones(valid_q) == 32'(occ_q))
	// Occupancy never shrinks.
	`LFU_ASSERT(a_occ_monotonic, clk, arst_n, 1'b1 |=> occ_q >= $past(occ_q))
	// An accepted beat always starts a scan.
	`LFU_ASSERT(a_accept_scans, clk, arst_n, (req.valid && req.ready) |=> state_q == ST_SCAN)
	// A finished get never overwrites a result that is still waiting.
	`LFU_ASSERT_NEVER(a_no_drop, clk, arst_n, done_en && rsp_valid_q && !rsp.ready)

endmodule
